// File: design/gmbs_pkg.sv
// shared types, constants and helpers for the maze backtracker step block
// no dependencies; every other design file refers to this package by scoped names
`default_nettype none

package gmbs_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 32;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

  localparam int COL_W      = $clog2(GRID_WIDTH);
  localparam int ROW_W      = $clog2(GRID_HEIGHT);
  localparam int POS_W      = ROW_W + COL_W;
  localparam int TILE_DEPTH = 1 << POS_W;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int SP_W       = $clog2(CELLS);
  localparam int DEPTH_W    = $clog2(CELLS + 1);

  // item field widths
  localparam int CELL_W = 10;
  localparam int RAND_W = 16;
  localparam int WALL_W = 3;
  localparam int CFG_W  = 10;

  // clearing pass walks every cell and every possible start cell value
  localparam int CFG_SPAN = 1 << CFG_W;
  localparam int PASS_LEN = (CELLS > CFG_SPAN) ? CELLS : CFG_SPAN;
  localparam int PASS_W   = $clog2(PASS_LEN);

  // item kinds
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_CARVE   = 1'b1;

  typedef enum logic [1:0] {
    TILE_CLEAR = 2'd0,
    TILE_WALL  = 2'd1,
    TILE_PATH  = 2'd2
  } tile_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic              kind;
    logic [RAND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] current_cell;
    logic              advanced;
    logic [CELL_W-1:0] next_cell;
    logic [WALL_W-1:0] walled_count;
    logic              finished;
  } rsp_t;

  typedef struct packed {
    logic  rd_en;
    pos_t  rd_addr;
    logic  wr_en;
    pos_t  wr_addr;
    tile_t wr_data;
  } tile_port_t;

  typedef struct packed {
    logic            rd_en;
    logic [SP_W-1:0] rd_addr;
    logic            wr_en;
    logic [SP_W-1:0] wr_addr;
    pos_t            wr_data;
  } stack_port_t;

  // linear cell index of a grid position
  function automatic logic [IDX_W-1:0] idx_of(input pos_t p);
    idx_of = IDX_W'(p.row) * IDX_W'(GRID_WIDTH) + IDX_W'(p.col);
  endfunction

endpackage

`default_nettype wire

// File: design/gmbs_tile_mem.sv
// tile map storage: one two-bit code per grid position, addressed by {row, col}
// one write and one registered read per cycle; types from gmbs_pkg
`default_nettype none

module gmbs_tile_mem (
  input  wire logic               clk,
  input  wire gmbs_pkg::tile_port_t port,
  output gmbs_pkg::tile_t          rdata
);

  gmbs_pkg::tile_t mem [gmbs_pkg::TILE_DEPTH];

  always_ff @(posedge clk) begin
    if (port.wr_en) begin
      mem[port.wr_addr] <= port.wr_data;
    end
    if (port.rd_en) begin
      rdata <= mem[port.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/gmbs_stack_mem.sv
// backtrack stack storage: grid positions indexed by stack slot
// one write and one registered read per cycle; types from gmbs_pkg
`default_nettype none

module gmbs_stack_mem (
  input  wire logic                clk,
  input  wire gmbs_pkg::stack_port_t port,
  output gmbs_pkg::pos_t            rdata
);

  gmbs_pkg::pos_t mem [gmbs_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (port.wr_en) begin
      mem[port.wr_addr] <= port.wr_data;
    end
    if (port.rd_en) begin
      rdata <= mem[port.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/gmbs_ctrl.sv
// step sequencer: clearing pass, stack top fetch, neighbour scan, mark and push/pop
// drives the tile and stack memories; types and constants from gmbs_pkg
`default_nettype none

module gmbs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  input  wire gmbs_pkg::req_t             req_item,
  output logic                            req_stall,
  input  wire logic [gmbs_pkg::CFG_W-1:0] start_cell,
  input  wire logic                       slot_free,
  output logic                            rsp_load,
  output gmbs_pkg::rsp_t                  rsp_next,
  output gmbs_pkg::tile_port_t            tile_port,
  input  wire gmbs_pkg::tile_t            tile_rdata,
  output gmbs_pkg::stack_port_t           stack_port,
  input  wire gmbs_pkg::pos_t             stack_rdata
);

  localparam logic [gmbs_pkg::PASS_W-1:0] PASS_LAST = gmbs_pkg::PASS_W'(gmbs_pkg::PASS_LEN - 1);
  localparam logic [gmbs_pkg::COL_W-1:0] COL_LAST = gmbs_pkg::COL_W'(gmbs_pkg::GRID_WIDTH - 1);
  localparam logic [gmbs_pkg::ROW_W-1:0] ROW_LAST = gmbs_pkg::ROW_W'(gmbs_pkg::GRID_HEIGHT - 1);
  localparam logic [gmbs_pkg::COL_W-1:0] COL_ONE = gmbs_pkg::COL_W'(1);
  localparam logic [gmbs_pkg::ROW_W-1:0] ROW_ONE = gmbs_pkg::ROW_W'(1);
  localparam logic [2:0] PH_LAST = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TOP, S_SCAN, S_MARK, S_INDEX, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN
  } dir_t;

  state_t                          state;
  logic                            restart;
  logic [gmbs_pkg::PASS_W-1:0]     pass_cnt;
  gmbs_pkg::pos_t                  walk;
  gmbs_pkg::pos_t                  walk_next;
  logic [gmbs_pkg::DEPTH_W-1:0]    depth;
  gmbs_pkg::pos_t                  cur;
  gmbs_pkg::pos_t                  nxt;
  dir_t                            dir;
  logic [2:0]                      phase;
  logic                            slot_vld;
  logic                            slot_nb;
  logic                            slot_cur;
  logic                            nb_clear;
  logic                            path_hit;
  gmbs_pkg::pos_t                  cand [4];
  logic [2:0]                      cand_n;
  logic [gmbs_pkg::WALL_W-1:0]     walled;
  logic                            adv;
  logic                            fin;
  logic [1:0]                      rnd_lo;
  logic [1:0]                      r3;
  gmbs_pkg::rsp_t                  res;

  logic                            nb_ok;
  gmbs_pkg::pos_t                  nb;
  logic                            lf_ok, rt_ok, up_ok, dn_ok;
  gmbs_pkg::pos_t                  lf_p, rt_p, up_p, dn_p, ul_p, ur_p, dl_p, dr_p;
  logic                            slot_ok;
  gmbs_pkg::pos_t                  slot;
  logic                            hit_now;
  logic                            wall_now;
  logic [4:0]                      dig_sum;
  logic [2:0]                      fold1;
  logic [2:0]                      fold2;
  logic [1:0]                      r3_next;
  logic [1:0]                      sel;
  logic                            can_push;
  logic                            in_grid;

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_EMIT) && slot_free;
  assign rsp_next  = res;
  assign can_push  = (cand_n != 3'd0) && (depth < gmbs_pkg::DEPTH_W'(gmbs_pkg::CELLS));
  assign in_grid   = ({1'b0, pass_cnt} < (gmbs_pkg::PASS_W + 1)'(gmbs_pkg::CELLS));

  // walker over the grid in index order, wrapping at the last cell
  always_comb begin
    walk_next = walk;
    if (walk.col == COL_LAST) begin
      walk_next.col = '0;
      walk_next.row = (walk.row == ROW_LAST) ? '0 : walk.row + ROW_ONE;
    end else begin
      walk_next.col = walk.col + COL_ONE;
    end
  end

  // remainder of the random value by three: four is one modulo three, so the
  // two-bit digits are summed and the sum folded down the same way
  always_comb begin
    dig_sum = '0;
    for (int i = 0; i < gmbs_pkg::RAND_W / 2; i++) begin
      dig_sum = dig_sum + 5'(req_item.random_value[2*i +: 2]);
    end
    fold1   = 3'(dig_sum[1:0]) + 3'(dig_sum[3:2]) + 3'(dig_sum[4]);
    fold2   = 3'(fold1[1:0]) + 3'(fold1[2]);
    r3_next = (fold2 >= 3'd3) ? 2'(fold2 - 3'd3) : fold2[1:0];
  end

  // edge neighbour of the current cell in the scanned direction
  always_comb begin
    nb    = cur;
    nb_ok = 1'b0;
    unique case (dir)
      DIR_LEFT: begin
        nb_ok  = (cur.col != '0);
        nb.col = cur.col - COL_ONE;
      end
      DIR_RIGHT: begin
        nb_ok  = (cur.col != COL_LAST);
        nb.col = cur.col + COL_ONE;
      end
      DIR_UP: begin
        nb_ok  = (cur.row != '0);
        nb.row = cur.row - ROW_ONE;
      end
      DIR_DOWN: begin
        nb_ok  = (cur.row != ROW_LAST);
        nb.row = cur.row + ROW_ONE;
      end
    endcase
  end

  // cells around the neighbour
  always_comb begin
    lf_ok = (nb.col != '0);
    rt_ok = (nb.col != COL_LAST);
    up_ok = (nb.row != '0);
    dn_ok = (nb.row != ROW_LAST);
    lf_p = nb;  lf_p.col = nb.col - COL_ONE;
    rt_p = nb;  rt_p.col = nb.col + COL_ONE;
    up_p = nb;  up_p.row = nb.row - ROW_ONE;
    dn_p = nb;  dn_p.row = nb.row + ROW_ONE;
    ul_p = up_p; ul_p.col = lf_p.col;
    ur_p = up_p; ur_p.col = rt_p.col;
    dl_p = dn_p; dl_p.col = lf_p.col;
    dr_p = dn_p; dr_p.col = rt_p.col;
  end

  // cell read in each scan phase: the neighbour, then its edge cells, then its forward corners
  always_comb begin
    slot    = nb;
    slot_ok = 1'b0;
    case (phase)
      3'd0: slot_ok = 1'b1;
      3'd1: begin slot = lf_p; slot_ok = lf_ok; end
      3'd2: begin slot = rt_p; slot_ok = rt_ok; end
      3'd3: begin slot = up_p; slot_ok = up_ok; end
      3'd4: begin slot = dn_p; slot_ok = dn_ok; end
      3'd5: begin
        unique case (dir)
          DIR_LEFT:  begin slot = ul_p; slot_ok = up_ok && lf_ok; end
          DIR_RIGHT: begin slot = ur_p; slot_ok = up_ok && rt_ok; end
          DIR_UP:    begin slot = ul_p; slot_ok = up_ok && lf_ok; end
          DIR_DOWN:  begin slot = dl_p; slot_ok = dn_ok && lf_ok; end
        endcase
      end
      3'd6: begin
        unique case (dir)
          DIR_LEFT:  begin slot = dl_p; slot_ok = dn_ok && lf_ok; end
          DIR_RIGHT: begin slot = dr_p; slot_ok = dn_ok && rt_ok; end
          DIR_UP:    begin slot = ur_p; slot_ok = up_ok && rt_ok; end
          DIR_DOWN:  begin slot = dr_p; slot_ok = dn_ok && rt_ok; end
        endcase
      end
      default: slot_ok = 1'b0;
    endcase
  end

  assign hit_now  = slot_vld && !slot_nb && !slot_cur && (tile_rdata == gmbs_pkg::TILE_PATH);
  assign wall_now = (state == S_SCAN) && nb_ok && (phase == PH_LAST) && nb_clear
                    && (path_hit || hit_now);

  always_comb begin
    case (cand_n)
      3'd2:    sel = {1'b0, rnd_lo[0]};
      3'd3:    sel = r3;
      3'd4:    sel = rnd_lo;
      default: sel = 2'd0;
    endcase
  end

  // memory accesses: at most one tile read and one tile write per cycle, never the
  // same cell in the same cycle, so no forwarding is needed
  always_comb begin
    tile_port         = '0;
    tile_port.wr_data = gmbs_pkg::TILE_CLEAR;
    stack_port        = '0;
    unique case (state)
      S_CLEAR: begin
        tile_port.wr_en   = in_grid;
        tile_port.wr_addr = walk;
        tile_port.wr_data = gmbs_pkg::TILE_CLEAR;
        stack_port.wr_en   = restart && (pass_cnt == gmbs_pkg::PASS_W'(start_cell));
        stack_port.wr_addr = '0;
        stack_port.wr_data = walk;
      end
      S_IDLE: begin
        stack_port.rd_en   = req_valid && (req_item.kind == gmbs_pkg::KIND_CARVE)
                             && (depth != '0);
        stack_port.rd_addr = gmbs_pkg::SP_W'(depth - gmbs_pkg::DEPTH_W'(1));
      end
      S_SCAN: begin
        tile_port.rd_en   = nb_ok && (phase != PH_LAST) && slot_ok;
        tile_port.rd_addr = slot;
        tile_port.wr_en   = wall_now;
        tile_port.wr_addr = nb;
        tile_port.wr_data = gmbs_pkg::TILE_WALL;
      end
      S_MARK: begin
        tile_port.wr_en    = 1'b1;
        tile_port.wr_addr  = cur;
        tile_port.wr_data  = gmbs_pkg::TILE_PATH;
        stack_port.wr_en   = can_push;
        stack_port.wr_addr = gmbs_pkg::SP_W'(depth);
        stack_port.wr_data = cand[sel];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      restart  <= 1'b0;
      pass_cnt <= '0;
      walk     <= '0;
      depth    <= '0;
      dir      <= DIR_LEFT;
      slot_vld <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (pass_cnt == gmbs_pkg::PASS_W'(start_cell)) begin
            cur <= walk;
          end
          walk     <= walk_next;
          pass_cnt <= pass_cnt + gmbs_pkg::PASS_W'(1);
          if (pass_cnt == PASS_LAST) begin
            restart <= 1'b0;
            if (restart) begin
              depth <= gmbs_pkg::DEPTH_W'(1);
              state <= S_INDEX;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            rnd_lo  <= req_item.random_value[1:0];
            r3      <= r3_next;
            walled  <= '0;
            adv     <= 1'b0;
            fin     <= 1'b0;
            nxt     <= '0;
            if (req_item.kind == gmbs_pkg::KIND_RESTART) begin
              restart  <= 1'b1;
              pass_cnt <= '0;
              walk     <= '0;
              state    <= S_CLEAR;
            end else if (depth == '0) begin
              cur   <= '0;
              fin   <= 1'b1;
              state <= S_INDEX;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_TOP: begin
          cur      <= stack_rdata;
          dir      <= DIR_LEFT;
          phase    <= '0;
          cand_n   <= '0;
          slot_vld <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          slot_vld <= 1'b0;
          if (nb_ok && (phase != PH_LAST)) begin
            slot_vld <= slot_ok;
            slot_nb  <= (phase == 3'd0);
            slot_cur <= (slot == cur);
            phase    <= phase + 3'd1;
          end
          if (phase == 3'd1) begin
            nb_clear <= (tile_rdata == gmbs_pkg::TILE_CLEAR);
          end
          path_hit <= (phase == 3'd0) ? 1'b0 : (path_hit || hit_now);
          if (!nb_ok || (phase == PH_LAST)) begin
            if (nb_ok && nb_clear) begin
              if (path_hit || hit_now) begin
                walled <= walled + gmbs_pkg::WALL_W'(1);
              end else begin
                cand[cand_n[1:0]] <= nb;
                cand_n            <= cand_n + 3'd1;
              end
            end
            phase <= '0;
            if (dir == DIR_DOWN) begin
              state <= S_MARK;
            end else begin
              dir <= dir_t'(dir + 2'd1);
            end
          end
        end
        S_MARK: begin
          if (cand_n == 3'd0) begin
            depth <= depth - gmbs_pkg::DEPTH_W'(1);
            fin   <= (depth == gmbs_pkg::DEPTH_W'(1));
          end else if (can_push) begin
            nxt   <= cand[sel];
            adv   <= 1'b1;
            depth <= depth + gmbs_pkg::DEPTH_W'(1);
          end
          state <= S_INDEX;
        end
        S_INDEX: begin
          res.current_cell <= gmbs_pkg::CELL_W'(gmbs_pkg::idx_of(cur));
          res.next_cell    <= adv ? gmbs_pkg::CELL_W'(gmbs_pkg::idx_of(nxt)) : '0;
          res.advanced     <= adv;
          res.walled_count <= walled;
          res.finished     <= fin;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/grid_maze_backtracker_step.sv
// maze backtracker step, top level. carve item: the stack top is fetched, each in-grid
// neighbour of the current cell is scanned by one tile memory read per cycle, the cell is
// marked and pushed or popped, and the result registered; the next item is taken once the
// result is in the output register. restart item: result after a clearing pass over the
// tile map and every start cell value. reset (synchronous, active high) runs the same
// clearing pass with the input stalled; stack depth and start_cell come up zero.
`default_nettype none

module grid_maze_backtracker_step (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input items
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire gmbs_pkg::req_t             req_item,
  // result items
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output gmbs_pkg::rsp_t                  rsp_item,
  // start cell register write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [gmbs_pkg::CFG_W-1:0] cfg_start_cell
);

  logic [gmbs_pkg::CFG_W-1:0] start_cell;
  logic                       rsp_load;
  gmbs_pkg::rsp_t             rsp_next;
  gmbs_pkg::tile_port_t       tile_port;
  gmbs_pkg::tile_t            tile_rdata;
  gmbs_pkg::stack_port_t      stack_port;
  gmbs_pkg::pos_t             stack_rdata;
  logic                       slot_free;

  // register writes are to arrive only while idle (the user's duty, not enforced here); they are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cell <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_cell <= cfg_start_cell;
    end
  end

  // output register: a finished item waits here while the sequencer moves on
  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_item <= rsp_next;
    end
  end

  // sequencer: clearing pass, stack top fetch, neighbour scan, mark and push/pop
  gmbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_item    (req_item),
    .req_stall   (req_stall),
    .start_cell  (start_cell),
    .slot_free   (slot_free),
    .rsp_load    (rsp_load),
    .rsp_next    (rsp_next),
    .tile_port   (tile_port),
    .tile_rdata  (tile_rdata),
    .stack_port  (stack_port),
    .stack_rdata (stack_rdata)
  );

  // tile map, one code per {row, col}
  gmbs_tile_mem u_tile_mem (
    .clk   (clk),
    .port  (tile_port),
    .rdata (tile_rdata)
  );

  // backtrack stack of grid positions; entries only read after being pushed
  gmbs_stack_mem u_stack_mem (
    .clk   (clk),
    .port  (stack_port),
    .rdata (stack_rdata)
  );

endmodule

`default_nettype wire

// File: design/gmbs_checker.sv
// port-level checks for the maze backtracker step block
// bound to grid_maze_backtracker_step; result type from gmbs_pkg
`default_nettype none

module gmbs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire gmbs_pkg::rsp_t rsp_item
);

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("result item changed while stalled");

  // one item in flight: the input stalls right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken again without a gap");

  // a result without a push leaves next_cell at zero
  a_next_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.advanced |-> rsp_item.next_cell == '0)
    else $error("next_cell set without a push");

  // a push never finishes the carve
  a_adv_fin: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.advanced |-> !rsp_item.finished)
    else $error("finished flagged on a push");

  // walled_count stays at most four, and a push leaves at least one neighbour unwalled
  a_wall_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.walled_count <= 3'd3)
                  || (rsp_item.walled_count == 3'd4 && !rsp_item.advanced))
    else $error("walled_count out of range");

endmodule

bind grid_maze_backtracker_step gmbs_checker u_gmbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

`default_nettype wire

// File: tb/grid_maze_backtracker_step_tb.sv
// testbench for the maze backtracker step block: predicts every carve and restart result
// from its own copy of the tile map and backtrack stack; depends on gmbs_pkg and the rtl
`timescale 1ns / 100ps

module grid_maze_backtracker_step_tb;

  // step directions, in the order the block scans neighbours
  typedef enum int {
    DIR_LEFT  = 0,
    DIR_RIGHT = 1,
    DIR_UP    = 2,
    DIR_DOWN  = 3
  } dir_t;

  localparam logic [gmbs_pkg::CFG_W-1:0] START_TOP_LEFT     = gmbs_pkg::CFG_W'(0);
  localparam logic [gmbs_pkg::CFG_W-1:0] START_TOP_RIGHT    =
    gmbs_pkg::CFG_W'(gmbs_pkg::GRID_WIDTH - 1);
  localparam logic [gmbs_pkg::CFG_W-1:0] START_BOTTOM_LEFT  =
    gmbs_pkg::CFG_W'(gmbs_pkg::CELLS - gmbs_pkg::GRID_WIDTH);
  localparam logic [gmbs_pkg::CFG_W-1:0] START_BOTTOM_RIGHT =
    gmbs_pkg::CFG_W'(gmbs_pkg::CELLS - 1);
  localparam logic [gmbs_pkg::CFG_W-1:0] START_MIDDLE       =
    gmbs_pkg::CFG_W'(gmbs_pkg::CELLS / 2 + gmbs_pkg::GRID_WIDTH / 2);

  localparam int RANDOM_ITEMS = 260;
  localparam int LONG_WALK    = 300;
  localparam int IDLE_PERCENT = 37;
  // extra wait after the final settle, covering the tail of the run
  localparam int SETTLE_CYCLES = 60;

  logic             clk = 1'b1;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  gmbs_pkg::req_t   req_item = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  gmbs_pkg::rsp_t   rsp_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [gmbs_pkg::CFG_W-1:0] cfg_start_cell = '0;

  // predictor state: tile map, backtrack trail and the start cell register
  gmbs_pkg::tile_t            maze_tiles [gmbs_pkg::CELLS];
  int                         trail [gmbs_pkg::CELLS];
  int                         trail_depth = 0;
  logic [gmbs_pkg::CFG_W-1:0] start_cell_reg = '0;

  gmbs_pkg::rsp_t expected_steps [$];
  gmbs_pkg::rsp_t oldest;
  int   errors = 0;
  int   items_sent = 0;
  bit   steady = 1'b0;   // when set neither side idles

  grid_maze_backtracker_step DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_item       (req_item),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp_item       (rsp_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_start_cell (cfg_start_cell)
  );

  // 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // neighbour of cell c one step in direction d, or -1 when off the grid
  function automatic int step_cell(input int c, input dir_t d);
    int col;
    int row;
    if (c < 0) return -1;
    col = c % gmbs_pkg::GRID_WIDTH;
    row = c / gmbs_pkg::GRID_WIDTH;
    case (d)
      DIR_LEFT:  return (col > 0) ? c - 1 : -1;
      DIR_RIGHT: return (col < gmbs_pkg::GRID_WIDTH - 1) ? c + 1 : -1;
      DIR_UP:    return (row > 0) ? c - gmbs_pkg::GRID_WIDTH : -1;
      default:   return (row < gmbs_pkg::GRID_HEIGHT - 1) ? c + gmbs_pkg::GRID_WIDTH : -1;
    endcase
  endfunction

  function automatic bit foreign_path(input int m, input int cur);
    return (m >= 0) && (m != cur) && (maze_tiles[m] == gmbs_pkg::TILE_PATH);
  endfunction

  // a clear neighbour c reached in direction d may not touch any other path:
  // its edge neighbours and the corners beside the cell beyond it in that direction
  function automatic bit touches_path(input int c, input dir_t d, input int cur);
    int   fwd;
    dir_t side_a;
    dir_t side_b;
    for (int k = DIR_LEFT; k <= DIR_DOWN; k++) begin
      if (foreign_path(step_cell(c, dir_t'(k)), cur)) return 1'b1;
    end
    fwd    = step_cell(c, d);
    side_a = (d == DIR_LEFT || d == DIR_RIGHT) ? DIR_UP : DIR_LEFT;
    side_b = (d == DIR_LEFT || d == DIR_RIGHT) ? DIR_DOWN : DIR_RIGHT;
    return foreign_path(step_cell(fwd, side_a), cur) || foreign_path(step_cell(fwd, side_b), cur);
  endfunction

  // applies one accepted item to the predictor and returns the result it should give
  function automatic gmbs_pkg::rsp_t carve_predict(input logic kind,
                                                   input logic [gmbs_pkg::RAND_W-1:0] rv);
    gmbs_pkg::rsp_t r;
    int   cand [4];
    int   cnt;
    int   cur;
    int   m;
    int   walled;
    r = '0;
    if (kind == gmbs_pkg::KIND_RESTART) begin
      foreach (maze_tiles[i]) maze_tiles[i] = gmbs_pkg::TILE_CLEAR;
      cur            = int'(start_cell_reg) % gmbs_pkg::CELLS;
      trail[0]       = cur;
      trail_depth    = 1;
      r.current_cell = gmbs_pkg::CELL_W'(cur);
    end else if (trail_depth == 0) begin
      // nothing left to carve: map and stack stay as they are
      r.finished = 1'b1;
    end else begin
      cur    = trail[trail_depth - 1];
      cnt    = 0;
      walled = 0;
      for (int k = DIR_LEFT; k <= DIR_DOWN; k++) begin
        m = step_cell(cur, dir_t'(k));
        if (m >= 0 && maze_tiles[m] == gmbs_pkg::TILE_CLEAR) begin
          if (touches_path(m, dir_t'(k), cur)) begin
            maze_tiles[m] = gmbs_pkg::TILE_WALL;
            walled++;
          end else begin
            cand[cnt] = m;
            cnt++;
          end
        end
      end
      maze_tiles[cur] = gmbs_pkg::TILE_PATH;
      r.current_cell  = gmbs_pkg::CELL_W'(cur);
      r.walled_count  = gmbs_pkg::WALL_W'(walled);
      if (cnt == 0) begin
        // dead end: backtrack
        trail_depth--;
        r.finished = (trail_depth == 0);
      end else if (trail_depth < gmbs_pkg::CELLS) begin
        m                  = cand[int'(rv) % cnt];
        trail[trail_depth] = m;
        trail_depth++;
        r.advanced  = 1'b1;
        r.next_cell = gmbs_pkg::CELL_W'(m);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // presents one item, holds it through any stall, predicts on acceptance;
  // valid is left high afterwards and is only dropped by an idle draw or by settle
  task automatic send_item(input logic kind, input logic [gmbs_pkg::RAND_W-1:0] rv);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= '{kind: kind, random_value: rv};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_steps.push_back(carve_predict(kind, rv));
    items_sent++;
  endtask

  // drops valid and waits for every outstanding result
  task automatic settle();
    req_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
  endtask

  // register write, only issued with the block idle
  task automatic write_start(input logic [gmbs_pkg::CFG_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_start_cell <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    start_cell_reg  = value;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [gmbs_pkg::CELL_W-1:0] got,
                             input logic [gmbs_pkg::CELL_W-1:0] want);
    if (got !== want)
      report($sformatf("%s got %0d expected %0d (cell %0d)", name, got, want,
                       oldest.current_cell));
  endtask

  // compares every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_steps.size() == 0) begin
        report($sformatf("result with nothing outstanding, current_cell %0d",
                         rsp_item.current_cell));
      end else begin
        oldest = expected_steps.pop_front();
        check_field("current_cell", rsp_item.current_cell, oldest.current_cell);
        check_field("advanced", gmbs_pkg::CELL_W'(rsp_item.advanced),
                    gmbs_pkg::CELL_W'(oldest.advanced));
        check_field("next_cell", rsp_item.next_cell, oldest.next_cell);
        check_field("walled_count", gmbs_pkg::CELL_W'(rsp_item.walled_count),
                    gmbs_pkg::CELL_W'(oldest.walled_count));
        check_field("finished", gmbs_pkg::CELL_W'(rsp_item.finished),
                    gmbs_pkg::CELL_W'(oldest.finished));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // carve steps before any restart find an empty stack and report finished
  task automatic test_empty_stack();
    send_item(gmbs_pkg::KIND_CARVE, '0);
    send_item(gmbs_pkg::KIND_CARVE, '1);
    settle();
  endtask

  // restart from the reset value of the start cell, then a few steps with
  // extreme random values and two drawn at random
  task automatic test_default_start();
    send_item(gmbs_pkg::KIND_RESTART, '1);
    send_item(gmbs_pkg::KIND_CARVE, '0);
    send_item(gmbs_pkg::KIND_CARVE, '1);
    send_item(gmbs_pkg::KIND_CARVE, '0);
    send_item(gmbs_pkg::KIND_CARVE, '1);
    send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    settle();
  endtask

  // far corner start, then an interior start with a double restart
  task automatic test_start_cells();
    write_start(START_BOTTOM_RIGHT);
    send_item(gmbs_pkg::KIND_RESTART, '0);
    repeat (5) send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    settle();
    write_start(START_MIDDLE);
    send_item(gmbs_pkg::KIND_RESTART, gmbs_pkg::RAND_W'($urandom));
    send_item(gmbs_pkg::KIND_RESTART, gmbs_pkg::RAND_W'($urandom));
    repeat (6) send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    settle();
  endtask

  // one long walk from the top right corner with neither side idling, running
  // into dead ends and backtracking along the way
  task automatic test_long_walk();
    write_start(START_TOP_RIGHT);
    steady = 1'b1;
    send_item(gmbs_pkg::KIND_RESTART, gmbs_pkg::RAND_W'($urandom));
    repeat (LONG_WALK) send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    steady = 1'b0;
    send_item(gmbs_pkg::KIND_CARVE, '1);
    send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
    settle();
  endtask

  // mostly restart-then-walk sequences of random length; now and then a
  // restart in the middle of a walk or a new start cell between walks
  task automatic test_random_walks();
    int stop_at;
    int walk_len;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        settle();
        case ($urandom_range(6))
          0:       write_start(START_TOP_LEFT);
          1:       write_start(START_BOTTOM_RIGHT);
          2:       write_start(START_TOP_RIGHT);
          3:       write_start(START_BOTTOM_LEFT);
          default: write_start(gmbs_pkg::CFG_W'($urandom));
        endcase
      end
      send_item(gmbs_pkg::KIND_RESTART, gmbs_pkg::RAND_W'($urandom));
      walk_len = $urandom_range(4, 90);
      repeat (walk_len) begin
        if ($urandom_range(99) < 2)
          send_item(gmbs_pkg::KIND_RESTART, gmbs_pkg::RAND_W'($urandom));
        else send_item(gmbs_pkg::KIND_CARVE, gmbs_pkg::RAND_W'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    // reset held first; the block then clears its map with input stalled
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stack();
    test_default_start();
    test_start_cells();
    test_long_walk();
    test_random_walks();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_steps.size() != 0)
      report($sformatf("%0d results never arrived", expected_steps.size()));
    if (errors == 0) begin
      $display("grid_maze_backtracker_step_tb: PASS");
    end else begin
      $display("grid_maze_backtracker_step_tb: FAIL");
    end
    $finish;
  end

  // watchdog: ends the run as a failure if it has not finished within 15 ms
  initial begin
    #15_000_000;
    $display("grid_maze_backtracker_step_tb: FAIL");
    $finish;
  end

endmodule
